[rtl/core/wfc_pkg.sv]
package wfc_pkg;

  localparam int unsigned WideW  = 64;
  localparam int unsigned WordW  = 32;
  localparam int unsigned ClassW = 3;

  localparam logic [ClassW-1:0] ClsNormal    = 3'd0;
  localparam logic [ClassW-1:0] ClsSubnormal = 3'd1;
  localparam logic [ClassW-1:0] ClsZero      = 3'd2;
  localparam logic [ClassW-1:0] ClsInf       = 3'd3;
  localparam logic [ClassW-1:0] ClsNan       = 3'd4;

  localparam logic [31:0] SrcExpOnes = 32'hffff_ffff;
  // biased source exponent of the smallest binary32 normal (-126)
  localparam logic [32:0] MinNormExp = 33'h0_7fff_ff81;
  // source bias minus binary32 bias
  localparam logic [32:0] BiasDelta  = 33'h0_7fff_ff80;
  // biased source exponent that maps to binary32 exponent 0xff
  localparam logic [32:0] OvflExp    = 33'h0_8000_007f;
  localparam logic [7:0]  DstExpOnes = 8'hff;

  typedef struct packed {
    logic [WordW-1:0]  fp32_word;
    logic [ClassW-1:0] source_class;
    logic [ClassW-1:0] result_class;
  } result_t;

endpackage

[rtl/core/wfc_convert.sv]
module wfc_convert (
  input  logic [wfc_pkg::WideW-1:0] wide_value_i,
  output wfc_pkg::result_t          result_o
);

  logic                       sign;
  logic [31:0]                expo;
  logic [30:0]                frac;
  logic [wfc_pkg::ClassW-1:0] src_cls;
  logic                       rnd;
  logic [23:0]                m_inc;
  logic [22:0]                mant;
  logic [32:0]                e_adj;
  logic                       denorm;
  logic                       ovfl;
  logic [32:0]                dif;
  logic                       big_shift;
  logic [4:0]                 sh;
  logic [23:0]                full;
  logic [23:0]                kept;
  logic                       sticky;
  logic [23:0]                kept_r;
  logic [32:0]                be;
  logic [22:0]                nan_m;
  logic [31:0]                word;
  logic [7:0]                 w_exp;
  logic [22:0]                w_frac;

  assign sign = wide_value_i[63];
  assign expo = wide_value_i[62:31];
  assign frac = wide_value_i[30:0];

  always_comb begin
    if (expo == wfc_pkg::SrcExpOnes) begin
      src_cls = (frac != '0) ? wfc_pkg::ClsNan : wfc_pkg::ClsInf;
    end else if (expo == '0) begin
      src_cls = (frac != '0) ? wfc_pkg::ClsSubnormal : wfc_pkg::ClsZero;
    end else begin
      src_cls = wfc_pkg::ClsNormal;
    end
  end

  // first rounding to 23 fraction bits, carry moves into the exponent
  assign rnd   = |frac[7:0];
  assign m_inc = {1'b0, frac[30:8]} + {23'd0, rnd};
  assign mant  = m_inc[22:0];
  assign e_adj = {1'b0, expo} + {32'd0, m_inc[23]};

  assign denorm = e_adj < wfc_pkg::MinNormExp;
  assign ovfl   = e_adj >= wfc_pkg::OvflExp;
  assign be     = e_adj - wfc_pkg::BiasDelta;

  // denormalizing shift with sticky rounding
  assign dif       = wfc_pkg::MinNormExp - e_adj;
  assign big_shift = dif >= 33'd24;
  assign sh        = dif[4:0];
  assign full      = {1'b1, mant};
  assign kept      = full >> sh;
  assign sticky    = |(full & ~(24'hff_ffff << sh));
  assign kept_r    = big_shift ? 24'd1 : (kept + {23'd0, sticky});

  assign nan_m = (frac[30:8] == '0) ? 23'd1 : frac[30:8];

  always_comb begin
    case (src_cls)
      wfc_pkg::ClsZero: begin
        word = {sign, 31'd0};
      end
      wfc_pkg::ClsNan: begin
        word = {sign, wfc_pkg::DstExpOnes, nan_m};
      end
      wfc_pkg::ClsInf: begin
        word = {sign, wfc_pkg::DstExpOnes, 23'd0};
      end
      default: begin
        if (denorm) begin
          word = {sign, 7'd0, kept_r};
        end else if (ovfl) begin
          word = {sign, wfc_pkg::DstExpOnes, 23'd0};
        end else begin
          word = {sign, be[7:0], mant};
        end
      end
    endcase
  end

  assign w_exp  = word[30:23];
  assign w_frac = word[22:0];

  always_comb begin
    result_o.fp32_word    = word;
    result_o.source_class = src_cls;
    if (w_exp == wfc_pkg::DstExpOnes) begin
      result_o.result_class = (w_frac != '0) ? wfc_pkg::ClsNan : wfc_pkg::ClsInf;
    end else if (w_exp == '0) begin
      result_o.result_class = (w_frac != '0) ? wfc_pkg::ClsSubnormal : wfc_pkg::ClsZero;
    end else begin
      result_o.result_class = wfc_pkg::ClsNormal;
    end
  end

endmodule

[rtl/core/wide_float_to_fp32_converter_core.sv]
// wide float to binary32 converter
// input channel: in_valid_i / in_stall_o with wide_value_i (sign bit 63,
//   32-bit exponent biased 0x7fffffff, 31-bit fraction)
// output channel: out_valid_o / out_stall_i with fp32_word_o, source_class_o
//   and result_class_o (0 normal, 1 subnormal, 2 zero, 3 infinity, 4 nan)
// a transaction happens on a rising edge with valid high and stall low
// an accepted transaction is stored in the input register and converted, then its
//   result is offered from the result register
// throughput: one transaction per cycle while out_stall_i is low, set by the single
//   conversion stage between the input register and the result register
// rounding is upward in magnitude, overflow gives infinity
// reset empties both registers, no result is offered until new input arrives
// while the receiver stalls the result holds; one more transaction is still
//   taken into the input register, after that in_stall_o follows out_stall_i
module wide_float_to_fp32_converter_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [wfc_pkg::WideW-1:0]          wide_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [wfc_pkg::WordW-1:0]          fp32_word_o,
  output logic [wfc_pkg::ClassW-1:0]         source_class_o,
  output logic [wfc_pkg::ClassW-1:0]         result_class_o
);

  logic                      in_valid_q;
  logic [wfc_pkg::WideW-1:0] in_data_q;
  logic                      out_valid_q;
  wfc_pkg::result_t          res_d;
  wfc_pkg::result_t          res_q;
  logic                      out_hold;
  logic                      in_take;

  assign out_hold   = out_valid_q && out_stall_i;
  assign in_stall_o = in_valid_q && out_hold;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (!out_hold) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= wide_value_i;
    end
    if (!out_hold && in_valid_q) begin
      res_q <= res_d;
    end
  end

  wfc_convert u_convert (
    .wide_value_i (in_data_q),
    .result_o     (res_d)
  );

  assign out_valid_o    = out_valid_q;
  assign fp32_word_o    = res_q.fp32_word;
  assign source_class_o = res_q.source_class;
  assign result_class_o = res_q.result_class;

  a_stall_needs_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o)
  ) else $error("input stalled without both registers full");

  a_nan_kept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && source_class_o == wfc_pkg::ClsNan) |-> result_class_o == wfc_pkg::ClsNan
  ) else $error("nan source did not give nan");

  a_nan_only_from_nan: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_class_o == wfc_pkg::ClsNan) |-> source_class_o == wfc_pkg::ClsNan
  ) else $error("nan result from non-nan source");

  a_zero_kept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && source_class_o == wfc_pkg::ClsZero) |->
      (result_class_o == wfc_pkg::ClsZero && fp32_word_o[30:0] == 31'd0)
  ) else $error("zero source did not give zero");

endmodule

[tb/sv/tb_wide_float_to_fp32_converter_core.sv]
`timescale 1ns / 1ps

module tb_wide_float_to_fp32_converter_core;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [wfc_pkg::WideW-1:0]    wide_value_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [wfc_pkg::WordW-1:0]    fp32_word_o;
  logic [wfc_pkg::ClassW-1:0]   source_class_o;
  logic [wfc_pkg::ClassW-1:0]   result_class_o;

  wfc_pkg::result_t fp32_expected_q[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  wide_float_to_fp32_converter_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .wide_value_i   (wide_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fp32_word_o    (fp32_word_o),
    .source_class_o (source_class_o),
    .result_class_o (result_class_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [wfc_pkg::ClassW-1:0] class_of_fp32(input logic [31:0] w);
    if (w[30:23] == wfc_pkg::DstExpOnes) begin
      return (w[22:0] != 0) ? wfc_pkg::ClsNan : wfc_pkg::ClsInf;
    end
    if (w[30:23] == 8'h00) begin
      return (w[22:0] != 0) ? wfc_pkg::ClsSubnormal : wfc_pkg::ClsZero;
    end
    return wfc_pkg::ClsNormal;
  endfunction

  function automatic wfc_pkg::result_t predict_result(input logic [63:0] v);
    logic             sgn;
    logic [31:0]      ex;
    logic [30:0]      fr;
    logic [23:0]      mant;
    longint           eu;
    longint           dif;
    longint           be;
    logic [31:0]      full;
    logic [31:0]      kept;
    logic             sticky;
    logic [31:0]      word;
    wfc_pkg::result_t r;
    sgn = v[63];
    ex  = v[62:31];
    fr  = v[30:0];
    if (ex == wfc_pkg::SrcExpOnes) begin
      r.source_class = (fr != 0) ? wfc_pkg::ClsNan : wfc_pkg::ClsInf;
    end else if (ex == 32'h0) begin
      r.source_class = (fr != 0) ? wfc_pkg::ClsSubnormal : wfc_pkg::ClsZero;
    end else begin
      r.source_class = wfc_pkg::ClsNormal;
    end
    word = 32'h0;
    if (r.source_class == wfc_pkg::ClsZero) begin
      word = 32'h0;
    end else if (r.source_class == wfc_pkg::ClsNan) begin
      // truncated payload, forced nonzero so the result stays a nan
      word = {1'b0, wfc_pkg::DstExpOnes, fr[30:8]};
      if (fr[30:8] == 0) begin
        word[0] = 1'b1;
      end
    end else if (r.source_class == wfc_pkg::ClsInf) begin
      word = {1'b0, wfc_pkg::DstExpOnes, 23'h0};
    end else begin
      eu = longint'({32'h0, ex}) - longint'(64'h7fff_ffff);
      mant = {1'b0, fr[30:8]};
      if (fr[7:0] != 0) begin
        mant = mant + 24'h1;
        if (mant == 24'h80_0000) begin
          mant = 24'h0;
          eu = eu + 1;
        end
      end
      if (eu < -126) begin
        dif = -126 - eu;
        full = {8'h0, 1'b1, mant[22:0]};
        if (dif >= 32) begin
          kept = 32'h0;
          sticky = 1'b1;
        end else begin
          kept = full >> dif;
          sticky = (full & ((32'h1 << dif) - 32'h1)) != 0;
        end
        if (sticky) begin
          kept = kept + 32'h1;
        end
        word = kept;
      end else begin
        be = eu + 127;
        if (be >= 255) begin
          word = {1'b0, wfc_pkg::DstExpOnes, 23'h0};
        end else begin
          word = {1'b0, be[7:0], mant[22:0]};
        end
      end
    end
    word[31] = sgn;
    r.fp32_word = word;
    r.result_class = class_of_fp32(word);
    return r;
  endfunction

  function automatic logic [63:0] make_wide(input logic sgn, input logic [31:0] ex,
                                            input logic [30:0] fr);
    return {sgn, ex, fr};
  endfunction

  // biased source exponent for an unbiased offset
  function automatic logic [31:0] src_exp(input int off);
    return 32'h7fff_ffff + 32'(off);
  endfunction

  function automatic logic [63:0] random_wide_value();
    int unsigned pick;
    logic [30:0] fr;
    logic        sgn;
    pick = $urandom_range(0, 99);
    sgn = 1'($urandom_range(0, 1));
    fr = 31'($urandom);
    if (pick < 40) begin
      return make_wide(sgn, src_exp(int'($urandom_range(0, 300)) - 160), fr);
    end else if (pick < 55) begin
      // denormalization edge, often with all ones kept so the rounding carries
      if ($urandom_range(0, 1)) begin
        fr[30:8] = 23'h7f_ffff;
      end
      return make_wide(sgn, src_exp(int'($urandom_range(0, 28)) - 152), fr);
    end else if (pick < 65) begin
      if ($urandom_range(0, 1)) begin
        fr[30:8] = 23'h7f_ffff;
      end
      return make_wide(sgn, src_exp(int'($urandom_range(0, 4)) + 125), fr);
    end else if (pick < 75) begin
      case ($urandom_range(0, 2))
        0: fr = 31'h0;
        1: fr = 31'($urandom_range(0, 255));
        default: ;
      endcase
      return make_wide(sgn, $urandom_range(0, 1) ? wfc_pkg::SrcExpOnes : 32'h0, fr);
    end
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got 0x%08h want 0x%08h at %0t", field, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic send_value(input logic [63:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    wide_value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    fp32_expected_q.push_back(predict_result(v));
    @(negedge clk_i);
  endtask

  task automatic test_special_classes();
    send_value(make_wide(1'b0, 32'h0, 31'h0));
    send_value(make_wide(1'b1, 32'h0, 31'h0));
    send_value(make_wide(1'b0, 32'h0, 31'h1));
    send_value(make_wide(1'b1, 32'h0, 31'h7fff_ffff));
    send_value(make_wide(1'b0, wfc_pkg::SrcExpOnes, 31'h0));
    send_value(make_wide(1'b1, wfc_pkg::SrcExpOnes, 31'h0));
    send_value(make_wide(1'b0, wfc_pkg::SrcExpOnes, 31'h7fff_ffff));
    send_value(make_wide(1'b0, wfc_pkg::SrcExpOnes, 31'h1));
    send_value(make_wide(1'b1, wfc_pkg::SrcExpOnes, 31'h100));
    send_value(make_wide(1'b1, wfc_pkg::SrcExpOnes, 31'h4000_0000));
  endtask

  task automatic test_rounding_and_overflow();
    send_value(make_wide(1'b0, src_exp(0), 31'h0));
    send_value(make_wide(1'b1, src_exp(0), 31'h1));
    send_value(make_wide(1'b0, src_exp(0), 31'h7fff_ffff));
    send_value(make_wide(1'b0, src_exp(127), 31'h7fff_ff00));
    send_value(make_wide(1'b1, src_exp(127), 31'h7fff_ff01));
    send_value(make_wide(1'b0, src_exp(128), 31'h0));
    send_value(make_wide(1'b1, 32'hffff_fffe, 31'h1234_5678));
    send_value(make_wide(1'b0, 32'h1, 31'h0));
  endtask

  task automatic test_denormalization();
    send_value(make_wide(1'b0, src_exp(-126), 31'h0));
    send_value(make_wide(1'b0, src_exp(-127), 31'h0));
    send_value(make_wide(1'b1, src_exp(-149), 31'h0));
    send_value(make_wide(1'b0, src_exp(-150), 31'h0));
    send_value(make_wide(1'b0, src_exp(-127), 31'h7fff_ffff));
    send_value(make_wide(1'b1, src_exp(-127), 31'h7fff_fe00));
    send_value(make_wide(1'b0, src_exp(-127), 31'h7fff_ff00));
    send_value(make_wide(1'b1, src_exp(-200), 31'h5555_5555));
  endtask

  task automatic test_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_value(random_wide_value());
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // check each result transaction against the oldest prediction
  always @(posedge clk_i) begin
    wfc_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fp32_expected_q.size() == 0) begin
        report_mismatch("unexpected result", fp32_word_o, 32'h0);
      end else begin
        want = fp32_expected_q.pop_front();
        if (fp32_word_o !== want.fp32_word) begin
          report_mismatch("fp32_word", fp32_word_o, want.fp32_word);
        end
        if (source_class_o !== want.source_class) begin
          report_mismatch("source_class", 32'(source_class_o), 32'(want.source_class));
        end
        if (result_class_o !== want.result_class) begin
          report_mismatch("result_class", 32'(result_class_o), 32'(want.result_class));
        end
      end
    end
  end

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    wide_value_i = '0;
    out_stall_i  = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct  = 7;
    recv_stall_pct = 72;
    test_special_classes();
    test_rounding_and_overflow();
    test_denormalization();
    test_random(340);

    send_idle_pct  = 72;
    recv_stall_pct = 7;
    test_random(340);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random(345);

    in_valid_i <= 1'b0;
    while (fp32_expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
